/* rtl/core/sebfb_pkg.sv */
// Package for the SPI escaped byte FIFO bridge: payload structs, command codes,
// byte constants, FIFO sizes and pointer helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sebfb_pkg;

   localparam int RX_DEPTH = 128;
   localparam int TX_DEPTH = 128;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);

   localparam logic [1:0] CMD_EXCHANGE = 2'd0;
   localparam logic [1:0] CMD_PUT      = 2'd1;
   localparam logic [1:0] CMD_GET      = 2'd2;

   localparam logic [7:0] ESC_BYTE  = 8'h0F;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] LF_BYTE   = 8'h0A;
   localparam logic [7:0] CR_BYTE   = 8'h0D;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       ok;
   } rsp_payload_type;

   function automatic logic [RX_PTR_W-1:0] rx_ptr_next(input logic [RX_PTR_W-1:0] ptr);
      logic [RX_PTR_W-1:0] res;
      if (ptr == RX_PTR_W'(RX_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + RX_PTR_W'(1);
      end
      return res;
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_ptr_next(input logic [TX_PTR_W-1:0] ptr);
      logic [TX_PTR_W-1:0] res;
      if (ptr == TX_PTR_W'(TX_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + TX_PTR_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/spi_escaped_byte_fifo_bridge.sv */
// Top level of the SPI escaped byte FIFO bridge: receive and transmit ring
// FIFOs in synchronous memories, escape handling and the result register.
// Depends on sebfb_pkg.
//
//   channel | ports                          | payload
//   --------+--------------------------------+----------------------------
//   request | req_valid, req_ready           | req_payload (command, data)
//   result  | rsp_valid, rsp_ready           | rsp_payload (out_byte, ok)
//
// Each item issues the FIFO memory reads (and the receive push or carriage
// return push) at accept, then uses the registered read data in ST_RESULT.
// A new request is not taken until the item leaves ST_RESULT.
// Reset is synchronous; FIFOs come up empty, memory contents are not cleared.
// A new request is taken while a result waits; the block then holds in
// ST_RESULT until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module spi_escaped_byte_fifo_bridge
   import sebfb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   typedef enum logic {ST_IDLE, ST_RESULT} state_type;

   state_type             state_ff, state_in;
   req_payload_type       item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic [RX_PTR_W-1:0]   rx_wr_ptr_ff, rx_wr_ptr_in, rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [TX_PTR_W-1:0]   tx_wr_ptr_ff, tx_wr_ptr_in, tx_rd_ptr_ff, tx_rd_ptr_in;
   logic                  rx_esc_pend_ff, rx_esc_pend_in;
   logic                  tx_esc_sent_ff, tx_esc_sent_in;

   logic [7:0]            rx_mem_ff [RX_DEPTH];
   logic [7:0]            tx_mem_ff [TX_DEPTH];
   logic [7:0]            rx_rdata_ff, tx_rdata_ff;

   logic                  accept, fire;
   logic [RX_PTR_W-1:0]   rx_wr_next;
   logic [TX_PTR_W-1:0]   tx_wr_next;
   logic                  rx_full, rx_empty, tx_full, tx_empty;
   logic                  rx_take, rx_wr_en;
   logic                  tx_wr_en;
   logic [7:0]            tx_wr_data;
   logic                  head_special;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign fire        = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign rx_wr_next = rx_ptr_next(rx_wr_ptr_ff);
   assign tx_wr_next = tx_ptr_next(tx_wr_ptr_ff);
   assign rx_full    = (rx_wr_next == rx_rd_ptr_ff);
   assign tx_full    = (tx_wr_next == tx_rd_ptr_ff);
   assign rx_empty   = (rx_wr_ptr_ff == rx_rd_ptr_ff);
   assign tx_empty   = (tx_wr_ptr_ff == tx_rd_ptr_ff);

   // receive half of an exchange runs in the accept cycle
   assign rx_take  = rx_esc_pend_ff ||
                     ((req_payload.data_byte != ESC_BYTE) &&
                      (req_payload.data_byte != IDLE_BYTE));
   assign rx_wr_en = accept && (req_payload.command == CMD_EXCHANGE) && rx_take && !rx_full;

   assign head_special = (tx_rdata_ff == ESC_BYTE) || (tx_rdata_ff == IDLE_BYTE);

   // single transmit write port: CR at accept, the put byte when the item fires
   always_comb begin
      tx_wr_en   = 1'b0;
      tx_wr_data = item_ff.data_byte;
      if (accept && (req_payload.command == CMD_PUT) &&
          (req_payload.data_byte == LF_BYTE) && !tx_full) begin
         tx_wr_en   = 1'b1;
         tx_wr_data = CR_BYTE;
      end else if (fire && (item_ff.command == CMD_PUT) && !tx_full) begin
         tx_wr_en   = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      rx_wr_ptr_in   = rx_wr_ptr_ff;
      rx_rd_ptr_in   = rx_rd_ptr_ff;
      tx_wr_ptr_in   = tx_wr_ptr_ff;
      tx_rd_ptr_in   = tx_rd_ptr_ff;
      rx_esc_pend_in = rx_esc_pend_ff;
      tx_esc_sent_in = tx_esc_sent_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rx_wr_en) begin
         rx_wr_ptr_in = rx_wr_next;
      end
      if (tx_wr_en) begin
         tx_wr_ptr_in = tx_wr_next;
      end

      if (accept) begin
         state_in = ST_RESULT;
         if (req_payload.command == CMD_EXCHANGE) begin
            if (rx_take) begin
               rx_esc_pend_in = 1'b0;
            end else if (req_payload.data_byte == ESC_BYTE) begin
               rx_esc_pend_in = 1'b1;
            end
         end
      end

      if (fire) begin
         state_in       = ST_IDLE;
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '0;
         case (item_ff.command)
            CMD_EXCHANGE: begin
               rsp_payload_in.ok       = 1'b1;
               rsp_payload_in.out_byte = IDLE_BYTE;
               if (!tx_empty) begin
                  if (tx_esc_sent_ff || !head_special) begin
                     rsp_payload_in.out_byte = tx_rdata_ff;
                     tx_rd_ptr_in            = tx_ptr_next(tx_rd_ptr_ff);
                     tx_esc_sent_in          = 1'b0;
                  end else begin
                     rsp_payload_in.out_byte = ESC_BYTE;
                     tx_esc_sent_in          = 1'b1;
                  end
               end
            end
            CMD_PUT: begin
               rsp_payload_in.ok = !tx_full;
            end
            CMD_GET: begin
               if (!rx_empty) begin
                  rsp_payload_in.out_byte = rx_rdata_ff;
                  rsp_payload_in.ok       = 1'b1;
                  rx_rd_ptr_in            = rx_ptr_next(rx_rd_ptr_ff);
               end
            end
            default: begin
               rsp_payload_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_payload_ff <= '0;
         rx_wr_ptr_ff   <= '0;
         rx_rd_ptr_ff   <= '0;
         tx_wr_ptr_ff   <= '0;
         tx_rd_ptr_ff   <= '0;
         rx_esc_pend_ff <= 1'b0;
         tx_esc_sent_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_payload_ff <= rsp_payload_in;
         rx_wr_ptr_ff   <= rx_wr_ptr_in;
         rx_rd_ptr_ff   <= rx_rd_ptr_in;
         tx_wr_ptr_ff   <= tx_wr_ptr_in;
         tx_rd_ptr_ff   <= tx_rd_ptr_in;
         rx_esc_pend_ff <= rx_esc_pend_in;
         tx_esc_sent_ff <= tx_esc_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   // receive FIFO memory; read data holds between accepts
   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         rx_mem_ff[rx_wr_ptr_ff] <= req_payload.data_byte;
      end
      if (accept) begin
         rx_rdata_ff <= rx_mem_ff[rx_rd_ptr_ff];
      end
   end

   // transmit FIFO memory
   always_ff @(posedge clock) begin
      if (tx_wr_en) begin
         tx_mem_ff[tx_wr_ptr_ff] <= tx_wr_data;
      end
      if (accept) begin
         tx_rdata_ff <= tx_mem_ff[tx_rd_ptr_ff];
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RESULT))
      else $error("accepted transfer did not move to result cycle");

   a_rx_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rx_wr_en |-> (rx_wr_next != rx_rd_ptr_ff))
      else $error("receive FIFO written while full");

   a_tx_no_overrun: assert property (@(posedge clock) disable iff (reset)
      tx_wr_en |-> (tx_wr_next != tx_rd_ptr_ff))
      else $error("transmit FIFO written while full");

   a_esc_needs_data: assert property (@(posedge clock) disable iff (reset)
      tx_esc_sent_ff |-> !tx_empty)
      else $error("escape sent with transmit FIFO empty");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result raised outside result cycle");
`endif

endmodule

`default_nettype wire
